/* sv/spc_pkg.sv */
package spc_pkg;

    localparam int unsigned HDR_LEN  = 4;
    localparam int unsigned CRC_LEN  = 2;
    localparam logic [15:0] CRC_POLY = 16'h8005;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HDR_ERR   = 2'd1,
        ST_CRC_ERR   = 2'd2,
        ST_TOO_SHORT = 2'd3
    } status_t;

    typedef enum logic {
        S_RUN  = 1'b0,
        S_EMIT = 1'b1
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take_byte;
        logic take_idle;
        logic emit;
    } spc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic emit_last;
    } spc_sts_t;

    // expected header byte FF FF FD 00
    function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = 8'hFF;
            2'd1:    b = 8'hFF;
            2'd2:    b = 8'hFD;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* sv/spc_ctrl.sv */
module spc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_idle,
    output logic              in_ready,
    input  spc_pkg::spc_sts_t sts,
    output spc_pkg::spc_cmd_t cmd
);
    import spc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.take_byte = 1'b0;
        cmd.take_idle = 1'b0;
        cmd.emit      = 1'b0;
        case (state_reg)
            S_RUN:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = in_valid && !in_idle;
                cmd.take_idle = in_valid && in_idle;
                if (in_valid && in_idle)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

endmodule

/* sv/spc_datapath.sv */
module spc_datapath #(
    parameter int unsigned PAYLOAD_BYTES = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  spc_pkg::spc_cmd_t cmd,
    output spc_pkg::spc_sts_t sts,
    input  logic [7:0]        rx_byte,
    input  logic              out_ready,
    output logic              out_valid,
    output spc_pkg::status_t  out_status,
    output logic [3:0]        out_index,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic [15:0]       out_frames,
    output logic [15:0]       out_hdr_errs
);
    import spc_pkg::*;

    localparam int unsigned CRC_SPAN  = HDR_LEN + PAYLOAD_BYTES;
    localparam int unsigned FRAME_LEN = CRC_SPAN + CRC_LEN;
    localparam int unsigned PW        = $clog2(FRAME_LEN + 1);
    localparam int unsigned IW        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    function automatic logic [15:0] crc_add(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic [PW-1:0] pos_reg;
    logic [15:0]   crc_reg;
    logic [15:0]   rx_crc_reg;
    logic          hdr_bad_reg;
    logic [15:0]   frames_reg;
    logic [15:0]   hdr_errs_reg;
    status_t       verdict_reg;
    logic [IW-1:0] idx_reg;
    logic [7:0]    store_reg [PAYLOAD_BYTES];

    logic          out_valid_reg;
    status_t       out_status_reg;
    logic [3:0]    out_index_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic [15:0]   out_frames_reg;
    logic [15:0]   out_hdr_errs_reg;

    logic [PW-1:0] store_off;
    logic          in_frame;
    logic          in_crc_span;
    logic          is_last_idx;

    assign store_off   = pos_reg - PW'(HDR_LEN);
    assign in_frame    = pos_reg < PW'(FRAME_LEN);
    assign in_crc_span = pos_reg < PW'(CRC_SPAN);
    assign is_last_idx = idx_reg == IW'(PAYLOAD_BYTES - 1);

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign sts.emit_last = (verdict_reg != ST_OK) || is_last_idx;

    // frame state, counters and verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            rx_crc_reg   <= '0;
            hdr_bad_reg  <= 1'b0;
            frames_reg   <= '0;
            hdr_errs_reg <= '0;
            verdict_reg  <= ST_OK;
            idx_reg      <= '0;
        end
        else
        begin
            if (cmd.take_byte && in_frame)
            begin
                if (pos_reg < PW'(HDR_LEN))
                begin
                    if (rx_byte != hdr_byte(pos_reg[1:0]))
                    begin
                        hdr_bad_reg <= 1'b1;
                    end
                end
                if (in_crc_span)
                begin
                    crc_reg <= crc_add(crc_reg, rx_byte);
                end
                else if (pos_reg == PW'(CRC_SPAN))
                begin
                    rx_crc_reg[7:0] <= rx_byte;
                end
                else
                begin
                    rx_crc_reg[15:8] <= rx_byte;
                end
                pos_reg <= pos_reg + PW'(1);
            end
            if (cmd.take_idle)
            begin
                frames_reg   <= frames_reg + 16'd1;
                hdr_errs_reg <= hdr_errs_reg + {15'd0, hdr_bad_reg};
                if (in_frame)
                begin
                    verdict_reg <= ST_TOO_SHORT;
                end
                else if (hdr_bad_reg)
                begin
                    verdict_reg <= ST_HDR_ERR;
                end
                else if (rx_crc_reg != crc_reg)
                begin
                    verdict_reg <= ST_CRC_ERR;
                end
                else
                begin
                    verdict_reg <= ST_OK;
                end
                pos_reg     <= '0;
                crc_reg     <= '0;
                rx_crc_reg  <= '0;
                hdr_bad_reg <= 1'b0;
                idx_reg     <= '0;
            end
            if (cmd.emit)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // payload bytes of the current frame
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && in_crc_span && (pos_reg >= PW'(HDR_LEN)))
        begin
            store_reg[store_off[IW-1:0]] <= rx_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg   <= verdict_reg;
            out_frames_reg   <= frames_reg;
            out_hdr_errs_reg <= hdr_errs_reg;
            if (verdict_reg == ST_OK)
            begin
                out_index_reg <= 4'(idx_reg);
                out_byte_reg  <= store_reg[idx_reg];
                out_last_reg  <= is_last_idx;
            end
            else
            begin
                out_index_reg <= 4'd0;
                out_byte_reg  <= 8'd0;
                out_last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_index    = out_index_reg;
    assign out_byte     = out_byte_reg;
    assign out_last     = out_last_reg;
    assign out_frames   = out_frames_reg;
    assign out_hdr_errs = out_hdr_errs_reg;

endmodule

/* sv/servo_packet_crc_checker.sv */
// Servo-bus frame checker.
// Input stream: one item per received byte (tuser = 0, byte in tdata) or
// a line-idle marker (tuser = 1) that closes the frame. A frame is the
// header FF FF FD 00, PAYLOAD_BYTES payload bytes and a little-endian
// CRC-16 (poly 0x8005, init 0, not reflected) over header and payload.
// Bytes past the end of the frame are dropped.
// Output stream: for a good frame, PAYLOAD_BYTES items with status ok and
// the payload bytes in order, tlast on the final one; otherwise a single
// status item (header error, CRC error or too short) with tlast set.
// Each item also carries the running frame and header-error counts.
// Throughput: a byte item is taken every cycle unless results are being
// emitted. An idle marker's verdict is registered, then the controller
// loads the results (1 or PAYLOAD_BYTES) into the output register in
// turn, each once the register is free; input is held off meanwhile.
// If the receiver stalls, the output register holds its item and the
// emit sequence waits; the next byte is taken once the last result is
// in the output register. Reset clears position, CRC, counters and the
// output valid; no clearing pass is needed.
module servo_packet_crc_checker #(
    parameter int unsigned PAYLOAD_BYTES = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] payload_index, [11:4] payload_byte, [27:12] frames_total,
    // [43:28] header_errors, [47:44] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import spc_pkg::*;

    spc_cmd_t    cmd;
    spc_sts_t    sts;
    status_t     out_status;
    logic [3:0]  out_index;
    logic [7:0]  out_byte;
    logic [15:0] out_frames;
    logic [15:0] out_hdr_errs;

    spc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_idle  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spc_datapath #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .rx_byte      (s_axis_tdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_status   (out_status),
        .out_index    (out_index),
        .out_byte     (out_byte),
        .out_last     (m_axis_tlast),
        .out_frames   (out_frames),
        .out_hdr_errs (out_hdr_errs)
    );

    assign m_axis_tdata = {4'd0, out_hdr_errs, out_frames, out_byte, out_index};
    assign m_axis_tuser = out_status;

endmodule

/* tb/servo_frame_monitor.sv */
`timescale 1ns / 1ps

module servo_frame_monitor #(
    parameter int unsigned PAYLOAD_BYTES = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] payload_index, [11:4] payload_byte, [27:12] frames_total,
    // [43:28] header_errors, [47:44] zero
    input  logic [47:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          results_pending
);
    import spc_pkg::*;

    localparam int unsigned CRC_END     = HDR_LEN + PAYLOAD_BYTES;
    localparam int unsigned FRAME_LEN   = CRC_END + CRC_LEN;
    // header FF FF FD 00, first byte in the low bits
    localparam logic [31:0] HDR_BYTES   = 32'h00FD_FFFF;

    typedef struct packed {
        status_t     status;
        logic [3:0]  index;
        logic [7:0]  data;
        logic        last;
        logic [15:0] frames;
        logic [15:0] hdr_errs;
    } frame_result_t;

    logic [4:0]    rx_pos;
    logic [15:0]   crc_run;
    logic [15:0]   crc_rx;
    logic          hdr_bad;
    logic [7:0]    payload_mem [PAYLOAD_BYTES];
    logic [15:0]   frame_cnt;
    logic [15:0]   hdr_err_cnt;
    frame_result_t awaited_results [$];
    int            mismatches = 0;

    // CRC-16, poly 0x8005, MSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
        end
    endtask

    task automatic push_result(input status_t st, input logic [3:0] idx,
                               input logic [7:0] data, input logic last);
        frame_result_t r;
        r.status   = st;
        r.index    = idx;
        r.data     = data;
        r.last     = last;
        r.frames   = frame_cnt;
        r.hdr_errs = hdr_err_cnt;
        awaited_results.push_back(r);
    endtask

    task automatic take_item(input logic op, input logic [7:0] b);
        status_t st;
        if (op == 1'b0)
        begin
            // bytes past the CRC are dropped
            if (rx_pos < FRAME_LEN)
            begin
                if (rx_pos < HDR_LEN)
                begin
                    if (b != HDR_BYTES[8*rx_pos +: 8])
                        hdr_bad = 1'b1;
                end
                else if (rx_pos < CRC_END)
                begin
                    payload_mem[4'(rx_pos - 5'(HDR_LEN))] = b;
                end
                if (rx_pos < CRC_END)
                    crc_run = crc16_next(crc_run, b);
                else if (rx_pos == CRC_END)
                    crc_rx[7:0] = b;
                else
                    crc_rx[15:8] = b;
                rx_pos++;
            end
        end
        else
        begin
            frame_cnt++;
            if (hdr_bad)
                hdr_err_cnt++;
            if (rx_pos < FRAME_LEN)
                st = ST_TOO_SHORT;
            else if (hdr_bad)
                st = ST_HDR_ERR;
            else if (crc_rx != crc_run)
                st = ST_CRC_ERR;
            else
                st = ST_OK;
            if (st == ST_OK)
            begin
                for (int i = 0; i < PAYLOAD_BYTES; i++)
                    push_result(ST_OK, i[3:0], payload_mem[i[3:0]], i == PAYLOAD_BYTES - 1);
            end
            else
            begin
                push_result(st, 4'd0, 8'd0, 1'b1);
            end
            rx_pos  = '0;
            crc_run = '0;
            crc_rx  = '0;
            hdr_bad = 1'b0;
        end
    endtask

    task automatic check_result();
        frame_result_t e;
        if (awaited_results.size() == 0)
        begin
            mismatches++;
            $error("result with none expected: tdata 0x%0h, tuser %0d",
                   m_axis_tdata, m_axis_tuser);
        end
        else
        begin
            e = awaited_results.pop_front();
            check_field("status", 16'(e.status), 16'(m_axis_tuser));
            check_field("payload_index", 16'(e.index), 16'(m_axis_tdata[3:0]));
            check_field("payload_byte", 16'(e.data), 16'(m_axis_tdata[11:4]));
            check_field("last", 16'(e.last), 16'(m_axis_tlast));
            check_field("frames_total", e.frames, m_axis_tdata[27:12]);
            check_field("header_errors", e.hdr_errs, m_axis_tdata[43:28]);
            check_field("tdata padding", 16'd0, 16'(m_axis_tdata[47:44]));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_pos      = '0;
            crc_run     = '0;
            crc_rx      = '0;
            hdr_bad     = 1'b0;
            frame_cnt   = '0;
            hdr_err_cnt = '0;
            awaited_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                take_item(s_axis_tuser[0], s_axis_tdata);
        end
        mismatch_count  <= mismatches;
        results_pending <= awaited_results.size();
    end

endmodule

/* tb/servo_packet_crc_checker_tb.sv */
`timescale 1ns / 1ps

module servo_packet_crc_checker_tb;

    localparam int unsigned PAYLOAD_BYTES = 12;
    localparam int unsigned FRAME_LEN     = spc_pkg::HDR_LEN + PAYLOAD_BYTES + spc_pkg::CRC_LEN;
    // A correct run stays well within this limit even in the slowest phase.
    localparam int          CYCLE_LIMIT   = 100_000;
    // wait at the end for stray results; leave slack
    localparam int          DRAIN_CYCLES  = 20;
    localparam int          PHASE_ITEMS   = 14;

    // operation codes carried in s_axis_tuser
    localparam logic        OP_BYTE       = 1'b0;
    localparam logic        OP_IDLE       = 1'b1;

    // directed payload: all-zero, all-one, single bits and alternating patterns
    localparam logic [8*PAYLOAD_BYTES-1:0] EDGE_PAYLOAD = 96'hCC33_F00F_AA55_FE7F_8001_FF00;

    typedef enum {
        FR_GOOD,
        FR_BAD_HDR,
        FR_BAD_CRC,
        FR_BAD_BOTH,
        FR_SHORT,
        FR_LONG,
        FR_NOISE
    } frame_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic [0:0]  s_axis_tuser = OP_BYTE; // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] payload_index, [11:4] payload_byte, [27:12] frames_total,
    // [43:28] header_errors, [47:44] zero
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // [1:0] status
    logic        m_axis_tlast;

    int mismatch_count;
    int results_pending;
    int send_gap_pct = 0;   // chance in 100 that the sender idles a cycle
    int stall_pct = 0;      // chance in 100 that the receiver stalls a cycle
    int counted_items = 0;  // items sent, not counting dropped trailing bytes
    int cycle_count;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    servo_packet_crc_checker #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    servo_frame_monitor #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Receiver backpressure, redrawn every cycle.
    always @(posedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= stall_pct);

    // One input item. Valid stays high from one item to the next unless the
    // sender decides to idle; each step carries at most one update of valid.
    task automatic send_item(input logic op, input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Hold the sender off until every predicted result has been taken.
    // The first edge lets the monitor's count catch up with the last item.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
    endtask

    // Build a well-formed frame around the payload, then damage it as the
    // kind asks, and send it followed by the idle marker.
    task automatic send_frame(input frame_kind_t kind,
                              input logic [8*PAYLOAD_BYTES-1:0] payload);
        logic [7:0]  fr [$];
        logic [15:0] crc;
        int          len;
        crc = 16'h0000;
        fr.push_back(8'hFF);
        fr.push_back(8'hFF);
        fr.push_back(8'hFD);
        fr.push_back(8'h00);
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            fr.push_back(payload[8*k +: 8]);
        for (int k = 0; k < FRAME_LEN - 2; k++)
            crc = u_mon.crc16_next(crc, fr[k]);
        // CRC goes out low byte first
        fr.push_back(crc[7:0]);
        fr.push_back(crc[15:8]);
        case (kind)
            FR_BAD_HDR:
            begin
                len = $urandom_range(3);
                fr[len] = fr[len] ^ (8'h01 << $urandom_range(7));
            end
            FR_BAD_CRC:
            begin
                // hit payload or CRC field, header stays clean
                len = $urandom_range(FRAME_LEN - 1, 4);
                fr[len] = fr[len] ^ (8'h01 << $urandom_range(7));
            end
            FR_BAD_BOTH:
            begin
                // header error must win over the CRC error
                len = $urandom_range(3);
                fr[len] = fr[len] ^ (8'h01 << $urandom_range(7));
                len = $urandom_range(FRAME_LEN - 1, FRAME_LEN - 2);
                fr[len] = fr[len] ^ (8'h01 << $urandom_range(7));
            end
            FR_SHORT:
            begin
                len = $urandom_range(FRAME_LEN - 1);
                while (fr.size() > len)
                    void'(fr.pop_back());
                if (len > 0 && $urandom_range(1) == 1)
                begin
                    len = $urandom_range(len > 4 ? 3 : len - 1);
                    fr[len] = fr[len] ^ (8'h01 << $urandom_range(7));
                end
            end
            FR_LONG:
            begin
                // trailing bytes must be dropped
                len = $urandom_range(3, 1);
                repeat (len)
                    fr.push_back(8'($urandom));
            end
            FR_NOISE:
            begin
                fr.delete();
                len = $urandom_range(FRAME_LEN + 2);
                repeat (len)
                    fr.push_back(8'($urandom));
            end
            default: ;
        endcase
        foreach (fr[k])
        begin
            send_item(OP_BYTE, fr[k]);
            if (k < FRAME_LEN)
                counted_items++;
        end
        // tdata is don't-care on the idle marker; keep it random
        send_item(OP_IDLE, 8'($urandom));
        counted_items++;
    endtask

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return FR_GOOD;
        else if (r < 52)
            return FR_BAD_HDR;
        else if (r < 64)
            return FR_BAD_CRC;
        else if (r < 70)
            return FR_BAD_BOTH;
        else if (r < 80)
            return FR_SHORT;
        else if (r < 90)
            return FR_LONG;
        else
            return FR_NOISE;
    endfunction

    function automatic logic [8*PAYLOAD_BYTES-1:0] random_payload();
        logic [8*PAYLOAD_BYTES-1:0] p;
        for (int k = 0; k < PAYLOAD_BYTES; k++)
            p[8*k +: 8] = 8'($urandom);
        return p;
    endfunction

    // Cycle limit; a correct run ends long before this.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("servo_packet_crc_checker_tb failed");
        $finish;
    end

    initial
    begin
        int base_items;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // ---- Directed, no idling on either side ----
        // Idle right after reset: zero-length frame, status too short.
        send_item(OP_IDLE, 8'h00);
        // Short frame whose second header byte is wrong: too short, and
        // the header error counter still moves.
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h7E);
        send_item(OP_IDLE, 8'hFF);
        // Good frame with edge-value payload and dropped trailing bytes.
        send_frame(FR_LONG, EDGE_PAYLOAD);
        // Sender holds off until everything is out.
        wait_drained();

        // ---- Random frames, one phase per idling mix ----
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    send_gap_pct = 78;
                    stall_pct <= 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct <= 78;
                end
                default:
                begin
                    send_gap_pct = 31;
                    stall_pct <= 31;
                end
            endcase
            base_items = counted_items;
            while (counted_items - base_items < PHASE_ITEMS)
                send_frame(pick_kind(), random_payload());
            wait_drained();
        end

        // Nothing expected any more; give the block time to show strays.
        stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
            $display("servo_packet_crc_checker_tb passed");
        else
            $display("servo_packet_crc_checker_tb failed");
        $finish;
    end

endmodule
